// ----- hw/rtl/sha512_compression_macros.svh -----
// ----------------------------------------------------------------------------
// SHA-512 compression assertion macros
// Assertion helpers for simulation; they compile to nothing for synthesis.
// ----------------------------------------------------------------------------
`ifndef SHA512_COMPRESSION_MACROS_SVH
`define SHA512_COMPRESSION_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SHA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/sha_pkg.sv -----
// ----------------------------------------------------------------------------
// SHA-512 package
// Types, round constants and round functions shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
    localparam int WordW = 64;
    localparam int BlockWords = 16;
    localparam int SchedWords = 80;
    localparam int NumRegs = 8;
    localparam int CfgIdxW = 4;

    typedef logic [WordW-1:0] t_word;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       store_word;
        logic [3:0] store_idx;
        logic       load_init;
        logic       start;
        logic       do_round;
        logic [6:0] round;
        logic       add_chain;
    } t_cmd;

    localparam t_word RoundK [SchedWords] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (WordW - n));
    endfunction

    function automatic t_word byte_rev(input t_word x);
        t_word r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        byte_rev = r;
    endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/sha_if.sv -----
// ----------------------------------------------------------------------------
// SHA-512 channel interfaces
// Valid/ready channels for message words, digest words and register writes.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] raw_word;
    logic        first_block;
    logic        last_block;
    modport source (output valid, raw_word, first_block, last_block, input ready);
    modport sink (input valid, raw_word, first_block, last_block, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_word;
    logic [2:0]  hash_index;
    logic        last_word;
    modport source (output valid, hash_word, hash_index, last_word, input ready);
    modport sink (input valid, hash_word, hash_index, last_word, output ready);
endinterface

interface sha_cfg_if;
    logic        valid;
    logic        ready;
    logic [3:0]  index;
    logic [63:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/sha_datapath.sv -----
// ----------------------------------------------------------------------------
// SHA-512 datapath
// Schedule window, working variables, chain value and initial-value registers.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_datapath (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire sha_pkg::t_cmd i_cmd,
    input  wire logic [63:0]   i_word,
    input  wire logic          i_cfg_we,
    input  wire logic [3:0]    i_cfg_idx,
    input  wire logic [63:0]   i_cfg_data,
    input  wire logic [2:0]    i_rd_idx,
    output logic [63:0]        o_rd_word
);
    import sha_pkg::*;

    t_word r_init  [NumRegs];
    t_word r_chain [NumRegs];
    t_word r_v     [NumRegs];
    t_word r_w     [BlockWords];

    t_word w_cur, w_new, s0, s1, big0, big1, ch, maj, t1, t2;
    t_word x1, x0;

    always_comb begin
        x1 = r_w[14];
        x0 = r_w[1];
        s1 = rotr(x1, 19) ^ rotr(x1, 61) ^ (x1 >> 6);
        s0 = rotr(x0, 1) ^ rotr(x0, 8) ^ (x0 >> 7);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = r_w[0];
        big1 = rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41);
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        big0 = rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39);
        maj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t1 = r_v[7] + big1 + ch + RoundK[i_cmd.round] + w_cur;
        t2 = big0 + maj;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NumRegs; i++) begin
                r_init[i]  <= '0;
                r_chain[i] <= '0;
                r_v[i]     <= '0;
            end
        end else begin
            if (i_cfg_we && !i_cfg_idx[3]) begin
                r_init[i_cfg_idx[2:0]] <= i_cfg_data;
            end
            if (i_cmd.load_init) begin
                for (int i = 0; i < NumRegs; i++) r_chain[i] <= r_init[i];
            end else if (i_cmd.add_chain) begin
                for (int i = 0; i < NumRegs; i++) r_chain[i] <= r_chain[i] + r_v[i];
            end
            if (i_cmd.start) begin
                for (int i = 0; i < NumRegs; i++) begin
                    r_v[i] <= i_cmd.load_init ? r_init[i] : r_chain[i];
                end
            end else if (i_cmd.do_round) begin
                for (int i = 1; i < NumRegs; i++) r_v[i] <= r_v[i-1];
                r_v[4] <= r_v[3] + t1;
                r_v[0] <= t1 + t2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.store_word) begin
            r_w[i_cmd.store_idx] <= byte_rev(i_word);
        end else if (i_cmd.do_round) begin
            for (int i = 0; i < BlockWords - 1; i++) r_w[i] <= r_w[i+1];
            r_w[BlockWords-1] <= w_new;
        end
    end

    assign o_rd_word = r_chain[i_rd_idx];
endmodule
`default_nettype wire

// ----- hw/rtl/sha_ctrl.sv -----
// ----------------------------------------------------------------------------
// SHA-512 controller
// Sequences word loading, rounds, chain update and digest output.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_ctrl #(
    parameter int ROUNDS = 80
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_first,
    input  wire logic    i_last,
    output logic         o_out_valid,
    input  wire logic    i_out_ready,
    output logic [2:0]   o_out_idx,
    output sha_pkg::t_cmd o_cmd
);
    import sha_pkg::*;

    t_state r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [6:0] r_round, n_round;
    logic [2:0] r_oidx, n_oidx;
    logic r_last, n_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_round <= '0;
            r_oidx  <= '0;
            r_last  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_round <= n_round;
            r_oidx  <= n_oidx;
            r_last  <= n_last;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt = r_cnt;
        n_round = r_round;
        n_oidx = r_oidx;
        n_last = r_last;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        o_cmd = '0;
        o_cmd.round = r_round;
        o_cmd.store_idx = r_cnt;
        unique case (r_state)
            ST_LOAD: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.store_word = 1'b1;
                    n_cnt = r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        o_cmd.start = 1'b1;
                        o_cmd.load_init = i_first;
                        n_last = i_last;
                        n_round = '0;
                        n_state = ST_ROUND;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.do_round = 1'b1;
                n_round = r_round + 7'd1;
                if (r_round == 7'(ROUNDS - 1)) n_state = ST_ADD;
            end
            ST_ADD: begin
                o_cmd.add_chain = 1'b1;
                n_oidx = '0;
                n_state = r_last ? ST_EMIT : ST_LOAD;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == 3'd7) n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    assign o_out_idx = r_oidx;
endmodule
`default_nettype wire

// ----- hw/rtl/sha512_compression.sv -----
// ----------------------------------------------------------------------------
// SHA-512 compression block
// Channel   | Role   | Contents
// i_msg     | sink   | raw_word, first_block, last_block
// o_digest  | source | hash_word, hash_index, last_word
// i_cfg     | sink   | index, data (initial chain words)
// Words are taken one per cycle while the block is loading; after the sixteenth the
// round loop runs ROUNDS rounds, one round per cycle, then the chain add follows.
// A last block is followed by 8 output transactions.
// Reset is synchronous and active low; no clearing pass is needed.
// Output stalls hold the digest state; input is not taken meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha512_compression_macros.svh"
module sha512_compression #(
    parameter int ROUNDS = 80
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sha_in_if.sink    i_msg,
    sha_out_if.source o_digest,
    sha_cfg_if.sink   i_cfg
);
    import sha_pkg::*;

    t_cmd cmd;
    logic [2:0] oidx;
    logic [63:0] rd_word;

    sha_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_msg.valid), .o_in_ready(i_msg.ready),
        .i_first(i_msg.first_block), .i_last(i_msg.last_block),
        .o_out_valid(o_digest.valid), .i_out_ready(o_digest.ready),
        .o_out_idx(oidx), .o_cmd(cmd)
    );

    sha_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_word(i_msg.raw_word),
        .i_cfg_we(i_cfg.valid), .i_cfg_idx(i_cfg.index), .i_cfg_data(i_cfg.data),
        .i_rd_idx(oidx), .o_rd_word(rd_word)
    );

    assign i_cfg.ready = 1'b1;
    assign o_digest.hash_word = rd_word;
    assign o_digest.hash_index = oidx;
    assign o_digest.last_word = (oidx == 3'd7);

    `SHA_ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, o_digest.valid, !i_msg.ready)
    `SHA_ASSERT_NXT(a_start_rounds, i_clk, i_rst_n, cmd.start, cmd.do_round && cmd.round == 7'd0)
    `SHA_ASSERT_IMP(a_excl, i_clk, i_rst_n, cmd.do_round, !cmd.store_word && !cmd.add_chain)
endmodule
`default_nettype wire

// ----- tb/sha512_compression_checker.sv -----
// ----------------------------------------------------------------------------
// SHA-512 compression checker
// Watches the message, digest and register-write channels, keeps its own
// model of the chain value, and compares every digest transaction with the
// oldest predicted digest word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha512_compression_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sha_in_if         i_msg,
    sha_out_if        i_digest,
    sha_cfg_if        i_cfg,
    output int        o_errors,
    output int        o_pending,
    output int        o_digests
);
    import sha_pkg::*;

    typedef struct {
        t_word      word;
        logic [2:0] index;
        logic       last;
    } t_digest_word;

    localparam t_word KTab [SchedWords] = '{
        64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
        64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
        64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
        64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
        64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
        64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
        64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
        64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
        64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
        64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
        64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
        64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
        64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
        64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
        64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
        64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
        64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
        64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
        64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
        64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
    };

    t_word         init_h [NumRegs];
    t_word         chain [8];
    t_word         window [BlockWords];
    logic [3:0]    word_cnt;
    t_digest_word  digest_q [$];

    function automatic t_word ror64(input t_word x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic t_word to_big_endian(input t_word x);
        t_word r;
        for (int i = 0; i < 8; i++) begin
            r[8*i +: 8] = x[8*(7-i) +: 8];
        end
        return r;
    endfunction

    task automatic compress_into_chain();
        t_word w [SchedWords];
        t_word v [8];
        t_word t1;
        t_word t2;
        for (int i = 0; i < SchedWords; i++) begin
            if (i < BlockWords) begin
                w[i] = window[i];
            end else begin
                w[i] = (ror64(w[i-2], 19) ^ ror64(w[i-2], 61) ^ (w[i-2] >> 6)) + w[i-7]
                     + (ror64(w[i-15], 1) ^ ror64(w[i-15], 8) ^ (w[i-15] >> 7)) + w[i-16];
            end
        end
        v = chain;
        for (int i = 0; i < SchedWords; i++) begin
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTab[i] + w[i];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) begin
            chain[i] = chain[i] + v[i];
        end
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_digests = 0;
    end

    always @(posedge i_clk) begin
        t_digest_word exp_w;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                init_h[i] = '0;
                chain[i] = '0;
            end
            word_cnt = '0;
            digest_q.delete();
        end else begin
            if (i_digest.valid && i_digest.ready) begin
                if (digest_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected digest transaction: word %h index %0d last %b",
                             $time, i_digest.hash_word, i_digest.hash_index,
                             i_digest.last_word);
                end else begin
                    exp_w = digest_q.pop_front();
                    if (i_digest.hash_word !== exp_w.word) begin
                        o_errors++;
                        $display("%0t: hash_word mismatch: expected %h, actual %h",
                                 $time, exp_w.word, i_digest.hash_word);
                    end
                    if (i_digest.hash_index !== exp_w.index) begin
                        o_errors++;
                        $display("%0t: hash_index mismatch: expected %0d, actual %0d",
                                 $time, exp_w.index, i_digest.hash_index);
                    end
                    if (i_digest.last_word !== exp_w.last) begin
                        o_errors++;
                        $display("%0t: last_word mismatch: expected %b, actual %b",
                                 $time, exp_w.last, i_digest.last_word);
                    end
                    if (exp_w.last) begin
                        o_digests++;
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready && i_cfg.index < NumRegs) begin
                init_h[i_cfg.index] = i_cfg.data;
            end
            if (i_msg.valid && i_msg.ready) begin
                window[word_cnt] = to_big_endian(i_msg.raw_word);
                word_cnt = word_cnt + 4'd1;
                if (word_cnt == 4'd0) begin
                    if (i_msg.first_block) begin
                        chain = init_h;
                    end
                    compress_into_chain();
                    if (i_msg.last_block) begin
                        for (int i = 0; i < 8; i++) begin
                            exp_w.word = chain[i];
                            exp_w.index = 3'(i);
                            exp_w.last = (i == 7);
                            digest_q.push_back(exp_w);
                        end
                    end
                end
            end
        end
        o_pending = digest_q.size();
    end
endmodule
`default_nettype wire

// ----- tb/sha512_compression_tb.sv -----
// ----------------------------------------------------------------------------
// SHA-512 compression testbench
// Drives random message blocks and initial-value register writes into the
// block under random idling on both channels, including a long digest stall
// and full drains, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module sha512_compression_tb;
    import sha_pkg::*;

    localparam int Limit = 600000;
    localparam int DrainCycles = 150;
    localparam logic [3:0] REG_INIT_H0 = 4'd0;
    localparam logic [3:0] REG_UNUSED = 4'd9;

    localparam t_word Sha512Iv [8] = '{
        64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
        64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
    };
    localparam t_word Sha384Iv [8] = '{
        64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
        64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
    };

    logic i_clk;
    logic i_rst_n;
    int   tx_idle;
    int   rx_idle;
    bit   hold_req;
    int   words_sent;
    int   errors;
    int   pending;
    int   digests;

    sha_in_if  msg ();
    sha_out_if dig ();
    sha_cfg_if cfg ();

    sha512_compression u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_msg    (msg),
        .o_digest (dig),
        .i_cfg    (cfg)
    );

    sha512_compression_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_msg     (msg),
        .i_digest  (dig),
        .i_cfg     (cfg),
        .o_errors  (errors),
        .o_pending (pending),
        .o_digests (digests)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        repeat (Limit) @(posedge i_clk);
        $display("sha512_compression_tb: done, errors");
        $finish;
    end

    initial begin
        dig.ready <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                dig.ready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 1'b0;
            end
            dig.ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    task automatic send_word(input t_word w, input logic first, input logic last);
        while ($urandom_range(99) < tx_idle) begin
            msg.valid <= 1'b0;
            @(negedge i_clk);
        end
        msg.valid <= 1'b1;
        msg.raw_word <= w;
        msg.first_block <= first;
        msg.last_block <= last;
        do @(posedge i_clk); while (!msg.ready);
        @(negedge i_clk);
        words_sent++;
    endtask

    task automatic drain();
        msg.valid <= 1'b0;
        cfg.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (SchedWords + BlockWords + 20) @(negedge i_clk);
    endtask

    task automatic write_init(input t_word vals [8]);
        for (int i = 0; i <= 8; i++) begin
            cfg.valid <= 1'b1;
            cfg.index <= (i == 8) ? REG_UNUSED : REG_INIT_H0 + 4'(i);
            cfg.data <= (i == 8) ? {$urandom, $urandom} : vals[i];
            do @(posedge i_clk); while (!cfg.ready);
            @(negedge i_clk);
        end
        cfg.valid <= 1'b0;
    endtask

    task automatic send_block(input logic first, input logic last);
        for (int i = 0; i < BlockWords; i++) begin
            if (i == BlockWords - 1) begin
                send_word({$urandom, $urandom}, first, last);
            end else begin
                send_word({$urandom, $urandom}, 1'($urandom), 1'($urandom));
            end
        end
    endtask

    task automatic run_phase(input int n_words);
        int target;
        int n_blocks;
        int left_blocks;
        target = words_sent + n_words;
        while (words_sent < target) begin
            n_blocks = $urandom_range(3, 1);
            left_blocks = (target - words_sent + BlockWords - 1) / BlockWords;
            if (n_blocks > left_blocks) begin
                n_blocks = left_blocks;
            end
            if ($urandom_range(99) < 80) begin
                for (int b = 0; b < n_blocks; b++) begin
                    send_block(b == 0, b == n_blocks - 1);
                end
            end else begin
                send_block(1'($urandom), 1'($urandom));
            end
        end
    endtask

    initial begin
        t_word vals [8];
        t_word edge_words [16];
        tx_idle = 0;
        rx_idle = 0;
        hold_req = 1'b0;
        words_sent = 0;
        i_rst_n <= 1'b0;
        msg.valid <= 1'b0;
        msg.raw_word <= '0;
        msg.first_block <= 1'b0;
        msg.last_block <= 1'b0;
        cfg.valid <= 1'b0;
        cfg.index <= REG_INIT_H0;
        cfg.data <= '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // With no first block, compression starts from the zero chain left by reset.
        edge_words = '{'0, '1, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
                       64'h0123456789abcdef, 64'h8000000000000000, 64'h1, 64'hff,
                       64'hff00000000000000, '0, '1, '0, '1, 64'h00ff00ff00ff00ff,
                       64'hff00ff00ff00ff00, 64'h8000000000000001};
        for (int i = 0; i < BlockWords; i++) begin
            send_word(edge_words[i], i == 15 ? 1'b0 : 1'($urandom),
                      i == 15 ? 1'b1 : 1'($urandom));
        end
        drain();

        write_init(Sha512Iv);
        tx_idle = 7;
        rx_idle = 87;
        run_phase(96);
        drain();

        for (int i = 0; i < 8; i++) vals[i] = '1;
        write_init(vals);
        tx_idle = 87;
        rx_idle = 7;
        run_phase(48);
        drain();
        for (int i = 0; i < 8; i++) vals[i] = '0;
        write_init(vals);
        run_phase(48);
        drain();

        write_init(Sha384Iv);
        tx_idle = 0;
        rx_idle = 0;
        hold_req = 1'b1;
        run_phase(48);
        drain();
        for (int i = 0; i < 8; i++) vals[i] = {$urandom, $urandom};
        write_init(vals);
        run_phase(48);
        drain();

        $display("Sent %0d message words in several initial-value settings; %0d digests",
                 words_sent, digests);
        $display("checked under both idling mixes, a long digest stall and full drains.");
        if (errors == 0 && pending == 0) begin
            $display("sha512_compression_tb: done, clean");
        end else begin
            $display("sha512_compression_tb: done, errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
